FILE: hdl/trd_pkg.sv
// shared types, constants and codes of the tga run-length pixel decoder
`timescale 1ns / 1ps
`default_nettype none

package trd_pkg;

    localparam int COUNT_BITS = 24;

    localparam int TOTAL_BITS = 24;
    localparam int BPP_BITS   = 3;
    localparam int ADDR_BITS  = 3;

    // register indexes
    localparam logic REG_BPP   = 1'b0;
    localparam logic REG_TOTAL = 1'b1;

    // decoder phase codes
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_RAW    = 2'd1;
    localparam logic [1:0] PH_RUN    = 2'd2;

    localparam logic [BPP_BITS-1:0]   BPP_RESET   = 3'd4;
    localparam logic [TOTAL_BITS-1:0] TOTAL_RESET = 24'd1;

    typedef struct packed {
        logic [BPP_BITS-1:0]   bytes_per_pixel;
        logic [TOTAL_BITS-1:0] pixel_total;
    } cfg_t;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        logic        image_end;
        logic        overflow_error;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/trd_apb_regs.sv
// apb configuration registers: pixel size and pixel total
`timescale 1ns / 1ps
`default_nettype none

module trd_apb_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [trd_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output trd_pkg::cfg_t                      cfg
);
    import trd_pkg::*;

    logic [BPP_BITS-1:0]   bpp_reg;
    logic [TOTAL_BITS-1:0] total_reg;
    logic                  wr_en;
    logic                  reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg   <= BPP_RESET;
            total_reg <= TOTAL_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_BPP:   bpp_reg   <= pwdata[BPP_BITS-1:0];
                REG_TOTAL: total_reg <= pwdata[TOTAL_BITS-1:0];
                default:   bpp_reg   <= bpp_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_BPP:   prdata = {{(32-BPP_BITS){1'b0}}, bpp_reg};
            REG_TOTAL: prdata = {{(32-TOTAL_BITS){1'b0}}, total_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg.bytes_per_pixel = bpp_reg;
    assign cfg.pixel_total     = total_reg;

endmodule

`default_nettype wire

FILE: hdl/trd_core.sv
// packet state, pixel assembly and pixel counting for one byte a cycle while step is high
`timescale 1ns / 1ps
`default_nettype none

module trd_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    byte_in,
    input  wire trd_pkg::cfg_t cfg,
    output logic               res_valid,
    output trd_pkg::result_t   res
);
    import trd_pkg::*;

    logic [1:0]            phase_reg, phase_next;
    logic [7:0]            left_reg, left_next;
    logic [1:0]            slot_reg, slot_next;
    logic [31:0]           asm_reg, asm_next;
    logic [COUNT_BITS-1:0] done_reg, done_next;

    logic [2:0]            bpp_eff;
    logic [COUNT_BITS-1:0] total_raw;
    logic [COUNT_BITS-1:0] total_eff;
    logic [31:0]           asm_fill;
    logic [7:0]            rep;
    logic [COUNT_BITS:0]   due_sum;
    logic [COUNT_BITS-1:0] done_add;
    logic                  in_packet;

    always_comb
    begin
        if (cfg.bytes_per_pixel == 3'd0)
            bpp_eff = 3'd1;
        else if (cfg.bytes_per_pixel > 3'd4)
            bpp_eff = 3'd4;
        else
            bpp_eff = cfg.bytes_per_pixel;
    end

    assign total_raw = COUNT_BITS'(cfg.pixel_total);
    assign total_eff = (total_raw == '0) ? COUNT_BITS'(1) : total_raw;

    assign in_packet = (phase_reg == PH_RAW) || (phase_reg == PH_RUN);
    assign asm_fill  = asm_reg | (32'(byte_in) << {slot_reg, 3'b000});
    assign rep       = (phase_reg == PH_RAW) ? 8'd1 : left_reg;
    assign due_sum   = {1'b0, done_reg} + (COUNT_BITS + 1)'(left_reg);
    assign done_add  = done_reg + COUNT_BITS'(rep);

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        slot_next  = slot_reg;
        asm_next   = asm_reg;
        done_next  = done_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (!in_packet)
        begin
            slot_next = 2'd0;
            asm_next  = '0;
            if (!byte_in[7])
            begin
                phase_next = PH_RAW;
                left_next  = byte_in + 8'd1;
            end
            else
            begin
                phase_next = PH_RUN;
                left_next  = byte_in - 8'd127;
            end
        end
        else if (({1'b0, slot_reg} + 3'd1) < bpp_eff)
        begin
            slot_next = slot_reg + 2'd1;
            asm_next  = asm_fill;
        end
        else
        begin
            res_valid = 1'b1;
            slot_next = 2'd0;
            asm_next  = '0;
            if (due_sum > {1'b0, total_eff})
            begin
                // packet overshoots the image: report and start over
                res.repeat_count   = left_reg;
                res.overflow_error = 1'b1;
                phase_next         = PH_HEADER;
                left_next          = '0;
                done_next          = '0;
            end
            else
            begin
                res.pixel_value  = asm_fill;
                res.repeat_count = rep;
                if (done_add == total_eff)
                begin
                    res.image_end = 1'b1;
                    phase_next    = PH_HEADER;
                    left_next     = '0;
                    done_next     = '0;
                end
                else
                begin
                    done_next = done_add;
                    if ((phase_reg == PH_RAW) && (left_reg > 8'd1))
                    begin
                        left_next = left_reg - 8'd1;
                    end
                    else
                    begin
                        left_next  = '0;
                        phase_next = PH_HEADER;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            left_reg  <= '0;
            slot_reg  <= '0;
            asm_reg   <= '0;
            done_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            slot_reg  <= slot_next;
            asm_reg   <= asm_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tga_rle_pixel_decoder.sv
// tga run-length pixel decoder: input byte register, decode core, result register
// a byte accepted into the input register is decoded once the result register is free, and its result is registered
// throughput: one byte per cycle unless held back, set by the state update in the core
// a full result register that is not taken holds back the input register
// asynchronous active-low reset: header phase, counters cleared, bytes_per_pixel 4,
// pixel_total 1, both pipeline registers empty
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_pixel_decoder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [7:0]                    data_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [31:0]                   pixel_value,
    output logic      [7:0]                    repeat_count,
    output logic                               image_end,
    output logic                               overflow_error,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [trd_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    import trd_pkg::*;

    cfg_t    cfg;
    result_t core_res;
    result_t res_reg;
    logic    core_res_valid;
    logic    in_valid_reg;
    logic    [7:0] byte_reg;
    logic    out_valid_reg;
    logic    advance;

    trd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    trd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .byte_in   (byte_reg),
        .cfg       (cfg),
        .res_valid (core_res_valid),
        .res       (core_res)
    );

    // byte in the input register moves on once the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance && core_res_valid)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= data_byte;
        if (advance && core_res_valid)
            res_reg <= core_res;
    end

    assign out_valid      = out_valid_reg;
    assign pixel_value    = res_reg.pixel_value;
    assign repeat_count   = res_reg.repeat_count;
    assign image_end      = res_reg.image_end;
    assign overflow_error = res_reg.overflow_error;

endmodule

`default_nettype wire

FILE: bench/trd_checker.sv
// checker for the tga run-length pixel decoder: tracks decode state and compares every result
`timescale 1ns / 1ps

module trd_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [31:0]                   pixel_value,
    input  wire logic [7:0]                    repeat_count,
    input  wire logic                          image_end,
    input  wire logic                          overflow_error,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic                          pready,
    input  wire logic [trd_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 pixels_seen,
    output int                                 overflows_seen,
    output int                                 image_ends_seen
);
    import trd_pkg::*;

    // shadow registers
    logic [BPP_BITS-1:0]   cfg_bpp;
    logic [TOTAL_BITS-1:0] cfg_total;

    // decode state
    logic [1:0]            dec_phase;
    logic [7:0]            pkt_left;
    logic [1:0]            slot;
    logic [31:0]           acc_pixel;
    logic [COUNT_BITS-1:0] done_count;

    result_t pixel_q[$];

    function automatic void restart_image();
        dec_phase  = PH_HEADER;
        pkt_left   = '0;
        slot       = '0;
        acc_pixel  = '0;
        done_count = '0;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        int            eb;
        logic [24:0]   lim;
        logic [7:0]    due;
        logic [7:0]    rep;
        logic [31:0]   pix;
        result_t       r;
        eb  = (cfg_bpp == 0) ? 1 : (cfg_bpp > 4) ? 4 : int'(cfg_bpp);
        lim = (cfg_total == 0) ? 25'd1 : {1'b0, cfg_total};
        if (dec_phase != PH_RAW && dec_phase != PH_RUN) begin
            slot      = '0;
            acc_pixel = '0;
            if (b < 8'd128) begin
                dec_phase = PH_RAW;
                pkt_left  = b + 8'd1;
            end
            else begin
                dec_phase = PH_RUN;
                pkt_left  = b - 8'd127;
            end
            return;
        end
        acc_pixel = acc_pixel | (32'(b) << (8 * slot));
        if (int'(slot) + 1 < eb) begin
            slot = slot + 2'd1;
            return;
        end
        pix       = acc_pixel;
        slot      = '0;
        acc_pixel = '0;
        due       = pkt_left;
        rep       = (dec_phase == PH_RAW) ? 8'd1 : due;
        // overshoot: the whole packet must fit in what is left of the image
        if ({1'b0, done_count} + 25'(due) > lim) begin
            r.pixel_value    = '0;
            r.repeat_count   = due;
            r.image_end      = 1'b0;
            r.overflow_error = 1'b1;
            restart_image();
            pixel_q.push_back(r);
            return;
        end
        done_count       = done_count + COUNT_BITS'(rep);
        r.pixel_value    = pix;
        r.repeat_count   = rep;
        r.overflow_error = 1'b0;
        r.image_end      = ({1'b0, done_count} == lim);
        if (r.image_end) begin
            restart_image();
        end
        else if (dec_phase == PH_RAW && due > 8'd1) begin
            pkt_left = due - 8'd1;
        end
        else begin
            pkt_left  = '0;
            dec_phase = PH_HEADER;
        end
        pixel_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            cfg_bpp   = BPP_RESET;
            cfg_total = TOTAL_RESET;
            restart_image();
            pixel_q.delete();
            fail_count      = 0;
            pending         = 0;
            pixels_seen     = 0;
            overflows_seen  = 0;
            image_ends_seen = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[ADDR_BITS-1:2] == REG_BPP)
                    cfg_bpp = pwdata[BPP_BITS-1:0];
                else if (paddr[ADDR_BITS-1:2] == REG_TOTAL)
                    cfg_total = pwdata[TOTAL_BITS-1:0];
            end
            if (in_valid && in_ready)
                decode_byte(data_byte);
            if (out_valid && out_ready) begin
                if (pixel_q.size() == 0) begin
                    $error("result with nothing expected: pixel %h count %0d end %0d err %0d",
                           pixel_value, repeat_count, image_end, overflow_error);
                    fail_count++;
                end
                else begin
                    want = pixel_q.pop_front();
                    if (pixel_value !== want.pixel_value) begin
                        $error("pixel_value: expected %h, actual %h",
                               want.pixel_value, pixel_value);
                        fail_count++;
                    end
                    if (repeat_count !== want.repeat_count) begin
                        $error("repeat_count: expected %0d, actual %0d",
                               want.repeat_count, repeat_count);
                        fail_count++;
                    end
                    if (image_end !== want.image_end) begin
                        $error("image_end: expected %0d, actual %0d",
                               want.image_end, image_end);
                        fail_count++;
                    end
                    if (overflow_error !== want.overflow_error) begin
                        $error("overflow_error: expected %0d, actual %0d",
                               want.overflow_error, overflow_error);
                        fail_count++;
                    end
                    if (want.overflow_error)
                        overflows_seen++;
                    else
                        pixels_seen++;
                    if (want.image_end)
                        image_ends_seen++;
                end
            end
            pending = pixel_q.size();
        end
    end

endmodule

FILE: bench/tb_tga_rle_pixel_decoder.sv
// testbench top for the tga run-length pixel decoder: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder;
    import trd_pkg::*;

    // receiver stall patterns
    localparam int RX_FREE  = 0;
    localparam int RX_COIN  = 1;
    localparam int RX_RARE  = 2;
    localparam int RX_THIRD = 3;

    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_BYTES = 1500;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           data_byte = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [31:0]          pixel_value;
    logic [7:0]           repeat_count;
    logic                 image_end;
    logic                 overflow_error;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    int fail_count;
    int pending;
    int pixels_seen;
    int overflows_seen;
    int image_ends_seen;

    logic [7:0] stream_q[$];
    int         sent_bytes = 0;
    int         burst_left = 0;
    int         setting_count = 0;
    int         hold_ticket = 0;

    // receiver state
    int hold_served;
    int rx_hold;
    int rx_mode;
    int rx_mode_left;
    int rx_tick;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    tga_rle_pixel_decoder u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_value    (pixel_value),
        .repeat_count   (repeat_count),
        .image_end      (image_end),
        .overflow_error (overflow_error),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    trd_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pixel_value     (pixel_value),
        .repeat_count    (repeat_count),
        .image_end       (image_end),
        .overflow_error  (overflow_error),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .pixels_seen     (pixels_seen),
        .overflows_seen  (overflows_seen),
        .image_ends_seen (image_ends_seen)
    );

    // receiver: changing stall patterns, plus one long hold-off on request
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready    <= 1'b0;
            hold_served  = 0;
            rx_hold      = 0;
            rx_mode      = RX_FREE;
            rx_mode_left = 0;
            rx_tick      = 0;
        end
        else begin
            if (hold_served != hold_ticket) begin
                hold_served = hold_ticket;
                rx_hold     = HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = $urandom_range(RX_FREE, RX_THIRD);
                    rx_mode_left = $urandom_range(20, 300);
                end
                rx_mode_left--;
                rx_tick++;
                case (rx_mode)
                    RX_FREE: out_ready <= 1'b1;
                    RX_COIN: out_ready <= 1'($urandom_range(0, 1));
                    RX_RARE: out_ready <= ($urandom_range(0, 7) != 0);
                    default: out_ready <= (rx_tick % 3 == 0);
                endcase
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // bus goes idle between transactions
        @(posedge clk);
    endtask

    task automatic send_stream();
        int gap;
        while (stream_q.size() > 0) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            in_valid  <= 1'b1;
            data_byte <= stream_q.pop_front();
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            burst_left--;
            sent_bytes++;
        end
        in_valid <= 1'b0;
    endtask

    // wait for every expected result, then for the pipeline to drain a trailing header
    task automatic settle();
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic add_packet(input int len, input bit is_run, input int eb, input int npix);
        stream_q.push_back(is_run ? 8'(len + 127) : 8'(len - 1));
        repeat (npix * eb) stream_q.push_back(8'($urandom));
    endtask

    // one image as a sequence of well-formed packets, now and then broken
    task automatic add_image(input int eb, input int et);
        int  left;
        int  len;
        int  lim;
        int  npk;
        int  pick;
        bit  is_run;
        left = et;
        npk  = 0;
        while (left > 0 && npk < 16) begin
            npk++;
            pick   = $urandom_range(0, 29);
            is_run = 1'($urandom_range(0, 1));
            if (pick == 0) begin
                repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom));
                return;
            end
            if (pick <= 2 && left < 128) begin
                // overshooting packet: only its first pixel is decoded
                len = $urandom_range(left + 1, 128);
                add_packet(len, is_run, eb, 1);
                return;
            end
            lim = ($urandom_range(0, 3) == 0) ? 128 : 6;
            len = $urandom_range(1, (left < lim) ? left : lim);
            add_packet(len, is_run, eb, is_run ? 1 : len);
            left -= len;
        end
    endtask

    initial begin
        logic [2:0]  bpp;
        logic [23:0] total;
        logic [2:0]  bpp_now;
        logic [23:0] total_now;
        int          eb;
        int          et;
        int          target;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 4-byte pixels, one-pixel image
        stream_q = {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h12, 8'h34, 8'h56, 8'h78};
        send_stream();
        settle();
        // size 0 acts as 1, total 0 acts as 1: longest run and longest raw both overshoot
        write_reg(REG_BPP, 32'hFFFF_FFF8);
        write_reg(REG_TOTAL, 32'hFF00_0000);
        stream_q = {8'hFF, 8'hAA, 8'h7F, 8'h55};
        send_stream();
        settle();
        // largest total, then pixel size and total changed in the middle of the image
        write_reg(REG_BPP, 32'd1);
        write_reg(REG_TOTAL, 32'h00FF_FFFF);
        stream_q = {8'hFF, 8'h01, 8'h00, 8'h02};
        send_stream();
        settle();
        write_reg(REG_BPP, 32'd2);
        write_reg(REG_TOTAL, 32'd130);
        stream_q = {8'h00, 8'h03, 8'h04};
        send_stream();
        settle();
        // oversized pixel setting acts as 4, then 3-byte pixels
        write_reg(REG_BPP, 32'd7);
        write_reg(REG_TOTAL, 32'd2);
        stream_q = {8'h81, 8'hAB, 8'hCD, 8'hEF, 8'h10};
        send_stream();
        settle();
        write_reg(REG_BPP, 32'd3);
        stream_q = {8'h81, 8'hAB, 8'hCD, 8'hEF};
        send_stream();
        settle();
        bpp_now   = 3'd3;
        total_now = 24'd2;

        while (sent_bytes < RANDOM_BYTES + 25) begin
            setting_count++;
            bpp = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 9))
                0:       total = 24'd0;
                1:       total = 24'hFF_FFFF;
                2:       total = 24'($urandom_range(200, 3000));
                default: total = 24'($urandom_range(1, 40));
            endcase
            if ($urandom_range(0, 3) != 0) begin
                write_reg(REG_BPP, {29'($urandom), bpp});
                bpp_now = bpp;
            end
            if ($urandom_range(0, 3) != 0) begin
                write_reg(REG_TOTAL, {8'($urandom), total});
                total_now = total;
            end
            eb = (bpp_now == 0) ? 1 : (bpp_now > 4) ? 4 : int'(bpp_now);
            et = (total_now == 0) ? 1 : int'(total_now);
            target = $urandom_range(30, 150);
            while (stream_q.size() < target)
                add_image(eb, et);
            if (setting_count == 1)
                hold_ticket++;
            send_stream();
            settle();
        end

        do @(negedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        @(negedge clk);
        $display("sent %0d stream bytes over %0d random settings", sent_bytes, setting_count);
        $display("checked %0d pixels, %0d overshoots, %0d image ends",
                 pixels_seen, overflows_seen, image_ends_seen);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
